FILE: hdl/sebd_pkg.sv
// ----------------------------------------------------------------------------
// Subband energy beat detector package
// Shared job type, scale constant and elaboration helpers.
// ----------------------------------------------------------------------------
package sebd_pkg;

    localparam int unsigned ENERGY_SCALE = 10000;
    localparam int SCALE_BITS = 14;
    localparam int BAND_BITS = 8;
    localparam int ENERGY_BITS = 32;
    localparam int VAR_BITS = 64;

    // One completed band handed from the front to the back end
    typedef struct packed {
        logic [BAND_BITS-1:0]   band;
        logic [ENERGY_BITS-1:0] energy;
        logic                   frame_end;
    } job_t;

    // Floor of log2, evaluated on parameters only
    function automatic int flog2(input int v);
        int n;
        int x;
        n = 0;
        x = v;
        for (int i = 0; i < 32; i++)
        begin
            if (x > 1)
            begin
                x = x >> 1;
                n = n + 1;
            end
        end
        return n;
    endfunction

endpackage

FILE: hdl/subband_energy_beat_detector.sv
// ----------------------------------------------------------------------------
// Subband energy beat detector
// Per-band energy, history mean and variance, with beat flagging.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Contents
// s_*       in         s_tvalid/s_tready   bins, band_end in tuser, frame_end tlast
// m_*       out        m_tvalid/m_tready   band results, beat in tuser
// cfg_*     in         cfg_valid/cfg_ready beat_threshold write
//
// A bin that does not close a band transfers with the input kept ready. A closing
// bin then holds the input off through two registered multiplies and a queue push,
// the push waiting while the queue is full. The back end walks one band's history
// at a time, for mean then variance, through the single read port of the history
// memory; a two-entry queue absorbs bursts.
// Reset clears counters and sums; history is undefined until written.
// ----------------------------------------------------------------------------
module subband_energy_beat_detector #(
    parameter int SPECTRUM_POINTS = 1024,
    parameter int SUBBANDS        = 32,
    parameter int HISTORY_DEPTH   = 64,
    parameter int BIN_BITS        = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [15:0] bin_value, [26:16] band_size, rest zero
    input  logic         s_tuser,   // [0] band_end
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // [7:0] band_index, [39:8] band_energy,
                                    // [71:40] mean_energy, [135:72] energy_variance
    output logic         m_tuser,   // [0] beat
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);
    import sebd_pkg::*;

    logic        fj_valid, fj_ready, bj_valid, bj_ready;
    job_t        fj, bj;
    logic [31:0] threshold_reg;

    assign cfg_ready = 1'b1;

    // Hold the threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= '0;
        else if (cfg_valid)
            threshold_reg <= cfg_data;
    end

    sebd_front #(
        .SPECTRUM_POINTS (SPECTRUM_POINTS),
        .SUBBANDS        (SUBBANDS),
        .BIN_BITS        (BIN_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .bin_value (s_tdata[15:0]),
        .band_size (s_tdata[26:16]),
        .band_end  (s_tuser),
        .frame_end (s_tlast),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job       (fj)
    );

    sebd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fj_valid),
        .push_ready (fj_ready),
        .push_job   (fj),
        .pop_valid  (bj_valid),
        .pop_ready  (bj_ready),
        .pop_job    (bj)
    );

    sebd_back #(
        .SUBBANDS      (SUBBANDS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (bj_valid),
        .job_ready       (bj_ready),
        .job             (bj),
        .threshold       (threshold_reg),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .band_index      (m_tdata[7:0]),
        .band_energy     (m_tdata[39:8]),
        .mean_energy     (m_tdata[71:40]),
        .energy_variance (m_tdata[135:72]),
        .beat            (m_tuser),
        .last_band       (m_tlast)
    );

endmodule

FILE: hdl/sebd_front.sv
// ----------------------------------------------------------------------------
// Subband energy beat detector front end
// Accumulates bins per band and scales the closed band to an energy.
// ----------------------------------------------------------------------------
module sebd_front #(
    parameter int SPECTRUM_POINTS = 1024,
    parameter int SUBBANDS        = 32,
    parameter int BIN_BITS        = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [15:0]   bin_value,
    input  logic [10:0]   band_size,
    input  logic          band_end,
    input  logic          frame_end,
    output logic          job_valid,
    input  logic          job_ready,
    output sebd_pkg::job_t job
);
    import sebd_pkg::*;

    localparam int BW = (BIN_BITS < 16) ? BIN_BITS : 16;
    localparam int FFT_SHIFT = flog2(SPECTRUM_POINTS);
    localparam int P1_BITS = ENERGY_BITS + SCALE_BITS;
    localparam int P2_BITS = P1_BITS + 11;

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_MUL   = 4'b0010,
        F_SCALE = 4'b0100,
        F_PUSH  = 4'b1000
    } fstate_t;

    fstate_t                state_reg, state_next;
    logic [31:0]            band_sum_reg;
    logic [BAND_BITS-1:0]   band_counter_reg;
    logic [31:0]            sum_reg;
    logic [10:0]            size_reg;
    logic [P1_BITS-1:0]     p1_reg;
    job_t                   job_reg;
    logic [32:0]            sum_wide;
    logic [31:0]            sum_sat;
    logic [P2_BITS-1:0]     p2;
    logic [P2_BITS-1:0]     p2_shift;
    logic                   accept;
    logic                   closes;

    assign accept   = in_valid && in_ready;
    assign closes   = band_end || frame_end;
    assign in_ready = (state_reg == F_IDLE);
    assign job_valid = (state_reg == F_PUSH);
    assign job      = job_reg;

    // Saturating running sum of the band
    assign sum_wide = {1'b0, band_sum_reg} + 33'(bin_value[BW-1:0]);
    assign sum_sat  = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];

    // Second product and scale shift
    assign p2       = P2_BITS'(p1_reg) * P2_BITS'(size_reg);
    assign p2_shift = p2 >> FFT_SHIFT;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (accept && closes) state_next = F_MUL;
            F_MUL:   state_next = F_SCALE;
            F_SCALE: state_next = F_PUSH;
            F_PUSH:  if (job_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= F_IDLE;
            band_sum_reg     <= '0;
            band_counter_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (!closes)
                begin
                    band_sum_reg <= sum_sat;
                end
                else
                begin
                    band_sum_reg <= '0;
                    if (frame_end)
                        band_counter_reg <= '0;
                    else if (32'(band_counter_reg) + 32'd1 >= 32'(SUBBANDS))
                        band_counter_reg <= '0;
                    else
                        band_counter_reg <= band_counter_reg + 1'b1;
                end
            end
        end
    end

    // Payload: hold the closed band and work out its energy
    always_ff @(posedge clk)
    begin
        if (accept && closes)
        begin
            sum_reg           <= sum_sat;
            size_reg          <= band_size;
            job_reg.band      <= band_counter_reg;
            job_reg.frame_end <= frame_end;
        end
        if (state_reg == F_MUL)
            p1_reg <= P1_BITS'(sum_reg) * P1_BITS'(ENERGY_SCALE);
        if (state_reg == F_SCALE)
            job_reg.energy <= (|p2_shift[P2_BITS-1:32]) ? 32'hFFFF_FFFF : p2_shift[31:0];
    end

endmodule

FILE: hdl/sebd_queue.sv
// ----------------------------------------------------------------------------
// Subband energy beat detector job queue
// Two-entry queue decoupling the front end from the history walk.
// ----------------------------------------------------------------------------
module sebd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  sebd_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output sebd_pkg::job_t pop_job
);
    import sebd_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

FILE: hdl/sebd_back.sv
// ----------------------------------------------------------------------------
// Subband energy beat detector back end
// Walks the band history for mean and variance, stores energy, reports.
// ----------------------------------------------------------------------------
module sebd_back #(
    parameter int SUBBANDS = 32,
    parameter int HISTORY_DEPTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  sebd_pkg::job_t job,
    input  logic [31:0]    threshold,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     band_index,
    output logic [31:0]    band_energy,
    output logic [31:0]    mean_energy,
    output logic [63:0]    energy_variance,
    output logic           beat,
    output logic           last_band
);
    import sebd_pkg::*;

    localparam int DEPTH  = SUBBANDS * HISTORY_DEPTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int IW     = $clog2(HISTORY_DEPTH);
    localparam int CW     = $clog2(HISTORY_DEPTH + 1);
    localparam int HSHIFT = flog2(HISTORY_DEPTH);
    localparam int MW     = 32 + CW;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MEAN = 4'b0010,
        B_VAR  = 4'b0100,
        B_DONE = 4'b1000
    } bstate_t;

    logic [31:0]   mem [DEPTH];
    bstate_t       state_reg, state_next;
    job_t          job_reg;
    logic [AW-1:0] base_reg;
    logic [CW-1:0] rd_cnt_reg;
    logic [CW-1:0] acc_cnt_reg;
    logic          rvalid_reg;
    logic          sq_valid_reg;
    logic [31:0]   rdata_reg;
    logic [63:0]   sq_reg;
    logic [MW-1:0] msum_reg;
    logic [31:0]   mean_reg;
    logic [63:0]   vacc_reg;
    logic [IW-1:0] ring_pos_reg;
    logic [CW-1:0] learn_reg;
    logic          out_valid_reg;
    logic          issue;
    logic          absorb;
    logic          phase_done;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic [MW-1:0] msum_shift;
    logic [31:0]   mean_val;
    logic [31:0]   diff;
    logic [64:0]   vsum;
    logic [63:0]   var_val;
    logic          load_out;

    assign job_ready  = (state_reg == B_IDLE);
    assign issue      = ((state_reg == B_MEAN) || (state_reg == B_VAR))
                        && (rd_cnt_reg != CW'(HISTORY_DEPTH));
    assign absorb     = (state_reg == B_MEAN) ? rvalid_reg : sq_valid_reg;
    assign phase_done = (acc_cnt_reg == CW'(HISTORY_DEPTH));
    assign rd_addr    = base_reg + AW'(rd_cnt_reg[IW-1:0]);
    assign wr_addr    = base_reg + AW'(ring_pos_reg);
    assign load_out   = (state_reg == B_DONE) && (!out_valid_reg || out_ready);
    assign wr_en      = load_out;

    assign msum_shift = msum_reg >> HSHIFT;
    assign mean_val   = (|msum_shift[MW-1:32]) ? 32'hFFFF_FFFF : msum_shift[31:0];
    assign diff       = (rdata_reg >= mean_reg) ? rdata_reg - mean_reg : mean_reg - rdata_reg;
    assign vsum       = {1'b0, vacc_reg} + {1'b0, sq_reg};
    assign var_val    = vacc_reg >> HSHIFT;

    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (job_valid) state_next = B_MEAN;
            B_MEAN: if (phase_done) state_next = B_VAR;
            B_VAR:  if (phase_done) state_next = B_DONE;
            B_DONE: if (load_out) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // History memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= job_reg.energy;
        rdata_reg <= mem[rd_addr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rd_cnt_reg    <= '0;
            acc_cnt_reg   <= '0;
            rvalid_reg    <= 1'b0;
            sq_valid_reg  <= 1'b0;
            ring_pos_reg  <= '0;
            learn_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rvalid_reg   <= issue;
            sq_valid_reg <= (state_reg == B_VAR) && rvalid_reg;
            if ((state_reg == B_IDLE) || ((state_reg == B_MEAN) && phase_done))
            begin
                rd_cnt_reg  <= '0;
                acc_cnt_reg <= '0;
            end
            else
            begin
                if (issue)
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                if (absorb && !phase_done)
                    acc_cnt_reg <= acc_cnt_reg + 1'b1;
            end
            // Retire the result and advance the frame state
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                if (job_reg.frame_end)
                begin
                    if (32'(ring_pos_reg) + 32'd1 >= 32'(HISTORY_DEPTH))
                        ring_pos_reg <= '0;
                    else
                        ring_pos_reg <= ring_pos_reg + 1'b1;
                    if (learn_reg != CW'(HISTORY_DEPTH))
                        learn_reg <= learn_reg + 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath: accumulate mean, then squared deviations
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE)
        begin
            job_reg  <= job;
            base_reg <= AW'(job.band) * AW'(HISTORY_DEPTH);
            msum_reg <= '0;
            vacc_reg <= '0;
        end
        if ((state_reg == B_MEAN) && rvalid_reg && !phase_done)
            msum_reg <= msum_reg + MW'(rdata_reg);
        if ((state_reg == B_MEAN) && phase_done)
            mean_reg <= mean_val;
        sq_reg <= 64'(diff) * 64'(diff);
        if ((state_reg == B_VAR) && sq_valid_reg && !phase_done)
            vacc_reg <= vsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : vsum[63:0];
        if (load_out)
        begin
            band_index      <= job_reg.band;
            band_energy     <= job_reg.energy;
            mean_energy     <= mean_reg;
            energy_variance <= var_val;
            beat            <= (learn_reg == CW'(HISTORY_DEPTH))
                               && (var_val > 64'(threshold));
            last_band       <= job_reg.frame_end;
        end
    end

endmodule
